### sv/rdsm_pkg.sv
package rdsm_pkg;

    localparam logic [14:0] AXIS_MAX    = 15'd32767;
    localparam logic [7:0]  CENTRE_BYTE = 8'h80;

    // Register indexes on the configuration port
    localparam logic REG_DEADZONE      = 1'b0;
    localparam logic REG_ANTI_DEADZONE = 1'b1;

    // One root bit per cell; root length and quotient length in bits
    localparam int SQ_STEPS  = 24;
    localparam int DIV_STEPS = 17;

    // Radicand and remainder widths of the square-root cell
    localparam int RAD_W  = 48;
    localparam int ROOT_W = 24;
    localparam int SREM_W = 26;

    // Divider cell widths
    localparam int DREM_W = 34;
    localparam int QUO_W  = 17;

    typedef struct packed {
        logic               vld;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [23:0]        m8;
        logic               ctr;
        logic [30:0]        om16;
        logic               ovx;
        logic               ovy;
    } t_ctx;

endpackage

### sv/rdsm_sqrt_cell.sv
module rdsm_sqrt_cell (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [rdsm_pkg::SREM_W-1:0]       i_rem,
    input  logic [rdsm_pkg::ROOT_W-1:0]       i_root,
    input  logic [rdsm_pkg::RAD_W-1:0]        i_rad,
    output logic [rdsm_pkg::SREM_W-1:0]       o_rem,
    output logic [rdsm_pkg::ROOT_W-1:0]       o_root,
    output logic [rdsm_pkg::RAD_W-1:0]        o_rad
);

    logic [rdsm_pkg::SREM_W+1:0] w_r2;
    logic [rdsm_pkg::SREM_W+1:0] w_trial;
    logic [rdsm_pkg::SREM_W+1:0] w_diff;
    logic                        w_ge;

    // Bring down the next two radicand bits and try root*4+1
    assign w_r2    = {i_rem, i_rad[rdsm_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_r2 >= w_trial);
    assign w_diff  = w_r2 - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_ge ? w_diff[rdsm_pkg::SREM_W-1:0] : w_r2[rdsm_pkg::SREM_W-1:0];
            o_root <= {i_root[rdsm_pkg::ROOT_W-2:0], w_ge};
            o_rad  <= {i_rad[rdsm_pkg::RAD_W-3:0], 2'b00};
        end
    end

endmodule

### sv/rdsm_div_cell.sv
module rdsm_div_cell (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [rdsm_pkg::DREM_W-1:0]       i_rem,
    input  logic [rdsm_pkg::QUO_W-1:0]        i_num,
    input  logic [rdsm_pkg::QUO_W-1:0]        i_quo,
    input  logic [rdsm_pkg::DREM_W-1:0]       i_den,
    output logic [rdsm_pkg::DREM_W-1:0]       o_rem,
    output logic [rdsm_pkg::QUO_W-1:0]        o_num,
    output logic [rdsm_pkg::QUO_W-1:0]        o_quo,
    output logic [rdsm_pkg::DREM_W-1:0]       o_den
);

    logic [rdsm_pkg::DREM_W:0] w_r2;
    logic [rdsm_pkg::DREM_W:0] w_diff;
    logic                      w_ge;

    // Restoring step: shift in one dividend bit, subtract when it fits
    assign w_r2   = {i_rem, i_num[rdsm_pkg::QUO_W-1]};
    assign w_ge   = (w_r2 >= {1'b0, i_den});
    assign w_diff = w_r2 - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= w_ge ? w_diff[rdsm_pkg::DREM_W-1:0] : w_r2[rdsm_pkg::DREM_W-1:0];
            o_num <= {i_num[rdsm_pkg::QUO_W-2:0], 1'b0};
            o_quo <= {i_quo[rdsm_pkg::QUO_W-2:0], w_ge};
            o_den <= i_den;
        end
    end

endmodule

### sv/radial_deadzone_stick_mapper_top.sv
// Throughput: one transaction per cycle while o_in_stall is low; the chains of
// square-root cells (24) and divider cells (17 for travel, 17 per axis for the
// rescale) each retire one bit per cycle unless stalled. A skid register behind
// the output catches one result while the output waits; input stalls until it drains.
// Synchronous active-low reset empties the pipeline and zeroes r_dz and r_adz.
module radial_deadzone_stick_mapper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_stick_x,
    input  logic signed [15:0] i_stick_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_axis_x_byte,
    output logic [7:0]         o_axis_y_byte,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    localparam int SQN = rdsm_pkg::SQ_STEPS;
    localparam int DVN = rdsm_pkg::DIV_STEPS;

    logic [14:0] r_dz;
    logic [14:0] r_adz;
    logic        en;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz  <= 15'd0;
            r_adz <= 15'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rdsm_pkg::REG_DEADZONE:      r_dz  <= i_cfg_data;
                rdsm_pkg::REG_ANTI_DEADZONE: r_adz <= i_cfg_data;
                default:                     r_adz <= r_adz;
            endcase
        end
    end

    logic r_skid_vld;
    assign en         = ~r_skid_vld;
    assign o_in_stall = r_skid_vld;

    // Squares
    rdsm_pkg::t_ctx     r_p1_ctx, n_p1_ctx, r_p2_ctx;
    logic signed [31:0] w_xx, w_yy;
    logic [31:0]        r_xx, r_yy, r_sq;

    assign w_xx = i_stick_x * i_stick_x;
    assign w_yy = i_stick_y * i_stick_y;

    always_comb begin
        n_p1_ctx     = '0;
        n_p1_ctx.vld = i_in_valid;
        n_p1_ctx.x   = i_stick_x;
        n_p1_ctx.y   = i_stick_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctx.vld <= 1'b0;
            r_p2_ctx.vld <= 1'b0;
        end else if (en) begin
            r_p1_ctx <= n_p1_ctx;
            r_p2_ctx <= r_p1_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx <= $unsigned(w_xx);
            r_yy <= $unsigned(w_yy);
            r_sq <= r_xx + r_yy;
        end
    end

    // Square-root chain
    logic [rdsm_pkg::SREM_W-1:0] w_sq_rem  [0:SQN];
    logic [rdsm_pkg::ROOT_W-1:0] w_sq_root [0:SQN];
    logic [rdsm_pkg::RAD_W-1:0]  w_sq_rad  [0:SQN];
    rdsm_pkg::t_ctx              r_sq_ctx  [0:SQN-1];

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = {r_sq, 16'd0};

    for (genvar k = 0; k < SQN; k++) begin : g_sq
        rdsm_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .i_rad  (w_sq_rad[k]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1]),
            .o_rad  (w_sq_rad[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQN; k++) r_sq_ctx[k].vld <= 1'b0;
        end else if (en) begin
            r_sq_ctx[0] <= r_p2_ctx;
            for (int k = 1; k < SQN; k++) r_sq_ctx[k] <= r_sq_ctx[k-1];
        end
    end

    // Deadzone test and travel numerator
    logic [23:0]    w_m8, w_src8;
    logic [22:0]    w_dz8, w_diff;
    logic           w_ctr;
    rdsm_pkg::t_ctx n_c_ctx, r_c_ctx;
    logic [22:0]    r_c_diff;

    assign w_m8  = w_sq_root[SQN];
    assign w_dz8 = {r_dz, 8'd0};
    assign w_ctr = (r_dz == rdsm_pkg::AXIS_MAX) || (w_m8 == 24'd0) || (w_m8 <= {1'b0, w_dz8});
    assign w_src8 = (w_m8 > {1'b0, rdsm_pkg::AXIS_MAX, 8'd0}) ?
                    {1'b0, rdsm_pkg::AXIS_MAX, 8'd0} : w_m8;
    assign w_diff = w_ctr ? 23'd0 : (w_src8[22:0] - w_dz8);

    always_comb begin
        n_c_ctx     = r_sq_ctx[SQN-1];
        n_c_ctx.m8  = w_m8;
        n_c_ctx.ctr = w_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_ctx.vld <= 1'b0;
        else if (en)  r_c_ctx     <= n_c_ctx;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_c_diff <= w_diff;
    end

    // Travel divider chain
    logic [rdsm_pkg::DREM_W-1:0] w_tv_rem [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_tv_num [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_tv_quo [0:DVN];
    logic [rdsm_pkg::DREM_W-1:0] w_tv_den [0:DVN];
    rdsm_pkg::t_ctx              r_tv_ctx [0:DVN-1];
    logic [14:0]                 w_dspan;

    assign w_dspan     = rdsm_pkg::AXIS_MAX - r_dz;
    assign w_tv_rem[0] = {12'd0, r_c_diff[22:1]};
    assign w_tv_num[0] = {r_c_diff[0], 16'd0};
    assign w_tv_quo[0] = '0;
    assign w_tv_den[0] = {11'd0, w_dspan, 8'd0};

    for (genvar k = 0; k < DVN; k++) begin : g_tv
        rdsm_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_tv_rem[k]),
            .i_num (w_tv_num[k]),
            .i_quo (w_tv_quo[k]),
            .i_den (w_tv_den[k]),
            .o_rem (w_tv_rem[k+1]),
            .o_num (w_tv_num[k+1]),
            .o_quo (w_tv_quo[k+1]),
            .o_den (w_tv_den[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DVN; k++) r_tv_ctx[k].vld <= 1'b0;
        end else if (en) begin
            r_tv_ctx[0] <= r_c_ctx;
            for (int k = 1; k < DVN; k++) r_tv_ctx[k] <= r_tv_ctx[k-1];
        end
    end

    // Output magnitude
    logic [16:0]    w_trav;
    logic [31:0]    w_om;
    rdsm_pkg::t_ctx n_m_ctx, r_m_ctx;

    assign w_trav = (w_tv_quo[DVN] > 17'd65536) ? 17'd65536 : w_tv_quo[DVN];
    assign w_om   = {1'b0, r_adz, 16'd0} + (w_trav * (rdsm_pkg::AXIS_MAX - r_adz));

    always_comb begin
        n_m_ctx      = r_tv_ctx[DVN-1];
        n_m_ctx.om16 = w_om[30:0];
    end

    // Component times magnitude
    logic signed [16:0] w_xe, w_ye;
    logic [16:0]        w_ax, w_ay;
    rdsm_pkg::t_ctx     r_n_ctx;
    logic [47:0]        r_numx, r_numy;

    assign w_xe = {r_m_ctx.x[15], r_m_ctx.x};
    assign w_ye = {r_m_ctx.y[15], r_m_ctx.y};
    assign w_ax = w_xe[16] ? $unsigned(-w_xe) : $unsigned(w_xe);
    assign w_ay = w_ye[16] ? $unsigned(-w_ye) : $unsigned(w_ye);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numx <= w_ax * r_m_ctx.om16;
            r_numy <= w_ay * r_m_ctx.om16;
        end
    end

    // Rounding offset, overflow check and divider set-up
    logic [47:0]                 w_nnx, w_nny;
    logic [rdsm_pkg::DREM_W-1:0] w_d2;
    logic                        w_ovx, w_ovy;
    rdsm_pkg::t_ctx              n_q_ctx, r_q_ctx;
    logic [rdsm_pkg::DREM_W-1:0] r_q_rx, r_q_ry, r_q_d2;
    logic [rdsm_pkg::QUO_W-1:0]  r_q_nx, r_q_ny;

    assign w_nnx = {r_numx[46:0], 1'b0} + {16'd0, r_n_ctx.m8, 8'd0};
    assign w_nny = {r_numy[46:0], 1'b0} + {16'd0, r_n_ctx.m8, 8'd0};
    assign w_d2  = {1'b0, r_n_ctx.m8, 9'd0};
    assign w_ovx = ({3'd0, w_nnx[47:17]} >= w_d2);
    assign w_ovy = ({3'd0, w_nny[47:17]} >= w_d2);

    always_comb begin
        n_q_ctx     = r_n_ctx;
        n_q_ctx.ovx = w_ovx;
        n_q_ctx.ovy = w_ovy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctx.vld <= 1'b0;
            r_n_ctx.vld <= 1'b0;
            r_q_ctx.vld <= 1'b0;
        end else if (en) begin
            r_m_ctx <= n_m_ctx;
            r_n_ctx <= r_m_ctx;
            r_q_ctx <= n_q_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_rx <= w_ovx ? '0 : {3'd0, w_nnx[47:17]};
            r_q_ry <= w_ovy ? '0 : {3'd0, w_nny[47:17]};
            r_q_nx <= w_nnx[16:0];
            r_q_ny <= w_nny[16:0];
            r_q_d2 <= w_d2;
        end
    end

    // Rescale divider chains, one lane per axis
    logic [rdsm_pkg::DREM_W-1:0] w_sx_rem [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_sx_num [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_sx_quo [0:DVN];
    logic [rdsm_pkg::DREM_W-1:0] w_sx_den [0:DVN];
    logic [rdsm_pkg::DREM_W-1:0] w_sy_rem [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_sy_num [0:DVN];
    logic [rdsm_pkg::QUO_W-1:0]  w_sy_quo [0:DVN];
    logic [rdsm_pkg::DREM_W-1:0] w_sy_den [0:DVN];
    rdsm_pkg::t_ctx              r_sc_ctx [0:DVN-1];

    assign w_sx_rem[0] = r_q_rx;
    assign w_sx_num[0] = r_q_nx;
    assign w_sx_quo[0] = '0;
    assign w_sx_den[0] = r_q_d2;
    assign w_sy_rem[0] = r_q_ry;
    assign w_sy_num[0] = r_q_ny;
    assign w_sy_quo[0] = '0;
    assign w_sy_den[0] = r_q_d2;

    for (genvar k = 0; k < DVN; k++) begin : g_sc
        rdsm_div_cell u_cell_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_sx_rem[k]),
            .i_num (w_sx_num[k]),
            .i_quo (w_sx_quo[k]),
            .i_den (w_sx_den[k]),
            .o_rem (w_sx_rem[k+1]),
            .o_num (w_sx_num[k+1]),
            .o_quo (w_sx_quo[k+1]),
            .o_den (w_sx_den[k+1])
        );
        rdsm_div_cell u_cell_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_sy_rem[k]),
            .i_num (w_sy_num[k]),
            .i_quo (w_sy_quo[k]),
            .i_den (w_sy_den[k]),
            .o_rem (w_sy_rem[k+1]),
            .o_num (w_sy_num[k+1]),
            .o_quo (w_sy_quo[k+1]),
            .o_den (w_sy_den[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DVN; k++) r_sc_ctx[k].vld <= 1'b0;
        end else if (en) begin
            r_sc_ctx[0] <= r_q_ctx;
            for (int k = 1; k < DVN; k++) r_sc_ctx[k] <= r_sc_ctx[k-1];
        end
    end

    // Saturate, offset and take the top byte
    function automatic logic [7:0] f_byte(input logic neg, input logic ovf,
                                          input logic [16:0] q);
        logic [16:0] t;
        t = 17'd32768 - q;
        if (!neg) begin
            if (ovf || q > 17'd32767) f_byte = 8'd255;
            else                      f_byte = {1'b1, q[14:8]};
        end else begin
            if (ovf || q >= 17'd32768) f_byte = 8'd0;
            else                       f_byte = t[15:8];
        end
    endfunction

    rdsm_pkg::t_ctx w_f_ctx;
    logic [7:0]     w_bx, w_by;

    assign w_f_ctx = r_sc_ctx[DVN-1];
    assign w_bx = w_f_ctx.ctr ? rdsm_pkg::CENTRE_BYTE :
                  f_byte(w_f_ctx.x[15], w_f_ctx.ovx, w_sx_quo[DVN]);
    assign w_by = w_f_ctx.ctr ? rdsm_pkg::CENTRE_BYTE :
                  f_byte(w_f_ctx.y[15], w_f_ctx.ovy, w_sy_quo[DVN]);

    // Output register with skid stage
    logic       r_out_vld;
    logic [7:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic       w_take;

    assign w_take        = r_out_vld & ~i_out_stall;
    assign o_out_valid   = r_out_vld;
    assign o_axis_x_byte = r_out_x;
    assign o_axis_y_byte = r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_f_ctx.vld) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end
        end else if (w_f_ctx.vld) begin
            if (!r_out_vld || w_take) begin
                r_out_x <= w_bx;
                r_out_y <= w_by;
            end else begin
                r_skid_x <= w_bx;
                r_skid_y <= w_by;
            end
        end
    end

endmodule
